### hdl/rim_pkg.sv
// Shared constants, register codes and payload types of the repeat index mapper.
`timescale 1ns / 1ps
`default_nettype none

package rim_pkg;

	// Index and shape geometry
	localparam int IDX_W      = 32;
	localparam int DIMS       = 6;
	localparam int PASSES     = DIMS + 1;
	localparam int DIV_W      = IDX_W + 1;
	localparam int DIM_W      = 16;
	localparam int AXIS_W     = 3;
	localparam int SLOT_W     = $clog2(DIMS);
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [AXIS_W-1:0] AXIS_RST   = AXIS_W'(5);
	localparam logic [DIM_W-1:0]  REPEAT_RST = DIM_W'(1);
	localparam logic [DIM_W-1:0]  DIM_RST    = DIM_W'(1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DIM0   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DIM5   = CFG_IDX_W'(7);

	// Input beat
	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic             is_last;
	} rim_in_t;

	// Output beat
	typedef struct packed {
		logic [IDX_W-1:0] src_index;
		logic             last_out;
	} rim_out_t;

	// Settings of one division pass, derived from the registers
	typedef struct packed {
		logic [DIV_W-1:0] divisor;
		logic             acc;
		logic [IDX_W-1:0] stride;
	} rim_pass_t;

	// Item state inside the pipeline
	typedef struct packed {
		logic [IDX_W-1:0] rem;
		logic [IDX_W-1:0] dq;
		logic [IDX_W-1:0] src;
		logic             last;
	} rim_stage_t;

endpackage

`default_nettype wire

### hdl/rim_cfg.sv
// Configuration registers, stride chain and per-pass divisor selection.
`timescale 1ns / 1ps
`default_nettype none

module rim_cfg import rim_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output rim_pass_t                  pass_cfg [0:PASSES-1]
);

	logic [AXIS_W-1:0] axis_q;
	logic [DIM_W-1:0]  rep_q;
	logic [DIM_W-1:0]  dim_q [0:DIMS-1];
	logic [IDX_W-1:0]  stride_q [0:DIMS-1];
	logic [SLOT_W-1:0] wr_slot;

	assign wr_slot = SLOT_W'(cfg_index - REG_DIM0);

	// Write registers; settle strides as running products of inner sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= AXIS_RST;
			rep_q  <= REPEAT_RST;
			for (int k = 0; k < DIMS; k++) begin
				dim_q[k]    <= DIM_RST;
				stride_q[k] <= IDX_W'(1);
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index) inside
					REG_AXIS:   axis_q <= cfg_data[AXIS_W-1:0];
					REG_REPEAT: rep_q  <= cfg_data[DIM_W-1:0];
					[REG_DIM0:REG_DIM5]: dim_q[wr_slot] <= cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			for (int k = 0; k < DIMS; k++) begin
				if (k == DIMS - 1) begin
					stride_q[k] <= IDX_W'(1);
				end else begin
					stride_q[k] <= IDX_W'(stride_q[k+1] * IDX_W'(dim_q[k+1]));
				end
			end
		end
	end

	// Map passes to slots: inner slots first, a repeat pass just before the axis slot
	always_comb begin
		int               rep_pass;
		int               slot;
		logic             has_axis;
		logic [SLOT_W-1:0] sel;
		logic             zero;
		rep_pass = DIMS - 1 - int'(axis_q);
		has_axis = (int'(axis_q) < DIMS);
		slot     = 0;
		sel      = '0;
		zero     = 1'b0;
		for (int j = 0; j < PASSES; j++) begin
			pass_cfg[j].divisor = DIV_W'(1);
			pass_cfg[j].acc     = 1'b0;
			pass_cfg[j].stride  = IDX_W'(1);
			if (has_axis && j == rep_pass) begin
				// divide by the repeat count, a zero count leaves the index whole
				if (rep_q != '0) begin
					pass_cfg[j].divisor = DIV_W'(rep_q);
				end
			end else if (has_axis || j < DIMS) begin
				slot = (has_axis && j > rep_pass) ? DIMS - j : DIMS - 1 - j;
				sel  = SLOT_W'(slot);
				zero = (dim_q[sel] == '0) ||
					(has_axis && AXIS_W'(sel) == axis_q && rep_q == '0);
				// a zero size takes the whole index: divisor above any index
				pass_cfg[j].divisor = zero ? (DIV_W'(1) << IDX_W) : DIV_W'(dim_q[sel]);
				pass_cfg[j].acc     = 1'b1;
				pass_cfg[j].stride  = stride_q[sel];
			end
		end
	end

endmodule

`default_nettype wire

### hdl/rim_div_step.sv
// One restoring division step: one quotient bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none

module rim_div_step import rim_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             up_valid,
	input  wire rim_stage_t       up_data,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  dn_valid,
	output rim_stage_t            dn_data
);

	logic [DIV_W-1:0] shifted;
	logic [DIV_W-1:0] diff;
	logic             ge;
	rim_stage_t       next;
	logic             vld_s1;
	rim_stage_t       dat_s1;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		shifted   = {up_data.rem, up_data.dq[IDX_W-1]};
		diff      = shifted - divisor;
		ge        = (shifted >= divisor);
		next      = up_data;
		next.rem  = ge ? diff[IDX_W-1:0] : shifted[IDX_W-1:0];
		next.dq   = {up_data.dq[IDX_W-2:0], ge};
	end

	// Advance the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= next;
		end
	end

	assign dn_valid = vld_s1;
	assign dn_data  = dat_s1;

endmodule

`default_nettype wire

### hdl/rim_accum.sv
// Scale a finished digit by its stride and add it into the source index.
`timescale 1ns / 1ps
`default_nettype none

module rim_accum import rim_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire rim_pass_t  pass_cfg,
	input  wire logic       up_valid,
	input  wire rim_stage_t up_data,
	output logic            dn_valid,
	output rim_stage_t      dn_data
);

	logic             vld_s1;
	logic [IDX_W-1:0] prod_s1;
	logic [IDX_W-1:0] quot_s1;
	logic [IDX_W-1:0] src_s1;
	logic             last_s1;
	logic             vld_s2;
	rim_stage_t       dat_s2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= up_valid;
			vld_s2 <= vld_s1;
		end
	end

	// Multiply the digit by the stride, then add; the quotient feeds the next pass
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= pass_cfg.acc ? IDX_W'(up_data.rem * pass_cfg.stride) : '0;
			quot_s1 <= up_data.dq;
			src_s1  <= up_data.src;
			last_s1 <= up_data.last;
			dat_s2.rem  <= '0;
			dat_s2.dq   <= quot_s1;
			dat_s2.src  <= src_s1 + prod_s1;
			dat_s2.last <= last_s1;
		end
	end

	assign dn_valid = vld_s2;
	assign dn_data  = dat_s2;

endmodule

`default_nettype wire

### hdl/rim_out_buf.sv
// Two-entry output buffer that decouples the pipeline from output stalls.
`timescale 1ns / 1ps
`default_nettype none

module rim_out_buf import rim_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire rim_out_t push_data,
	output logic          full,
	output logic          map_valid,
	input  wire logic     map_stall,
	output rim_out_t      map_data
);

	rim_out_t    mem_q [0:1];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign map_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = map_valid && !map_stall;
	assign map_data  = mem_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### hdl/tensor_repeat_index_map_core.sv
// Top level: maps output element indexes of a repeated tensor to source indexes.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  idx     | idx_valid / idx_stall | idx_data: out_index, is_last
//  map     | map_valid / map_stall | map_data: src_index, last_out
//  cfg     | cfg_valid / cfg_ready | cfg_index (register number), cfg_data
//
// One index enters per cycle while idx_stall is low. Each index passes the input stage,
// then seven passes of 32 one-bit divide stages plus 2 multiply/add stages, and then
// the output buffer. The whole pipeline holds while the two-entry output buffer is full,
// which is also when idx_stall is high. Reset empties the pipeline and restores the
// register defaults; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module tensor_repeat_index_map_core import rim_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  idx_valid,
	output logic                       idx_stall,
	input  wire rim_in_t               idx_data,
	output logic                       map_valid,
	input  wire logic                  map_stall,
	output rim_out_t                   map_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	rim_pass_t  pass_cfg [0:PASSES-1];
	logic       en;
	logic       full;
	logic       in_vld_s0;
	rim_stage_t in_dat_s0;
	logic       pass_v [0:PASSES];
	rim_stage_t pass_d [0:PASSES];
	logic       step_v [0:PASSES-1][0:IDX_W];
	rim_stage_t step_d [0:PASSES-1][0:IDX_W];
	rim_out_t   push_data;

	assign cfg_ready = 1'b1;
	assign en        = !full;
	assign idx_stall = full;

	rim_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pass_cfg  (pass_cfg)
	);

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s0 <= 1'b0;
		end else if (en) begin
			in_vld_s0 <= idx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_dat_s0.rem  <= '0;
			in_dat_s0.dq   <= idx_data.out_index;
			in_dat_s0.src  <= '0;
			in_dat_s0.last <= idx_data.is_last;
		end
	end

	assign pass_v[0] = in_vld_s0;
	assign pass_d[0] = in_dat_s0;

	// Division passes: one per slot plus the repeat pass
	for (genvar j = 0; j < PASSES; j++) begin : g_pass
		assign step_v[j][0] = pass_v[j];
		assign step_d[j][0] = pass_d[j];

		for (genvar b = 0; b < IDX_W; b++) begin : g_step
			rim_div_step u_step (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.up_valid (step_v[j][b]),
				.up_data  (step_d[j][b]),
				.divisor  (pass_cfg[j].divisor),
				.dn_valid (step_v[j][b+1]),
				.dn_data  (step_d[j][b+1])
			);
		end

		rim_accum u_accum (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.pass_cfg (pass_cfg[j]),
			.up_valid (step_v[j][IDX_W]),
			.up_data  (step_d[j][IDX_W]),
			.dn_valid (pass_v[j+1]),
			.dn_data  (pass_d[j+1])
		);
	end

	assign push_data.src_index = pass_d[PASSES].src;
	assign push_data.last_out  = pass_d[PASSES].last;

	rim_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && pass_v[PASSES]),
		.push_data (push_data),
		.full      (full),
		.map_valid (map_valid),
		.map_stall (map_stall),
		.map_data  (map_data)
	);

endmodule

`default_nettype wire

### tb/sv/tensor_repeat_index_map_core_tb.sv
// Self-checking testbench for the repeat index mapper core.
`timescale 1ns / 1ps

module tensor_repeat_index_map_core_tb;
	import rim_pkg::*;

	localparam int          PIPE_LATENCY   = 240;
	localparam int          QUIET_LIMIT    = 20000;
	localparam int          RAND_PER_SHAPE = 79;
	localparam int          MAX_REPORTS    = 10;
	localparam logic [63:0] IDX_MASK       = 64'h0000_0000_FFFF_FFFF;
	localparam logic [32:0] FULL_SPAN      = 33'h1_0000_0000;

	// One full register setting
	typedef struct packed {
		logic [AXIS_W-1:0]          axis;
		logic [DIM_W-1:0]           rep;
		logic [DIMS-1:0][DIM_W-1:0] dims;
	} shape_t;

	// Mirror of the register file plus the queue of source indexes still owed
	class index_map_sb;
		logic [AXIS_W-1:0] axis;
		logic [DIM_W-1:0]  rep;
		logic [DIM_W-1:0]  dims [DIMS];
		rim_out_t          pending_src [$];
		int                errors;
		int                reports;
		int                accepted;
		int                checked;

		function new();
			axis = AXIS_RST;
			rep  = REPEAT_RST;
			foreach (dims[k])
				dims[k] = DIM_RST;
			errors   = 0;
			reports  = 0;
			accepted = 0;
			checked  = 0;
		endfunction

		// Indexes past the last size register are dropped by the block
		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_AXIS)
				axis = data[AXIS_W-1:0];
			else if (idx == REG_REPEAT)
				rep = data;
			else if (idx >= REG_DIM0 && idx <= REG_DIM5)
				dims[idx - REG_DIM0] = data;
		endfunction

		// Split over output sizes, shrink the repeat digit, rebuild over input sizes
		function logic [IDX_W-1:0] source_index(logic [IDX_W-1:0] idx);
			logic [63:0] rest;
			logic [63:0] src;
			logic [63:0] stride;
			logic [63:0] in_sz;
			logic [63:0] out_sz;
			logic [63:0] digit;
			logic        on_axis;
			int          k;
			rest   = 64'(idx);
			src    = '0;
			stride = 64'd1;
			for (k = DIMS - 1; k >= 0; k--) begin
				in_sz   = 64'(dims[k]);
				on_axis = (k == int'(axis));
				out_sz  = on_axis ? ((in_sz * 64'(rep)) & IDX_MASK) : in_sz;
				// a zero-sized slot swallows everything that is left
				if (out_sz == 0) begin
					digit = rest;
					rest  = '0;
				end else begin
					digit = rest % out_sz;
					rest  = rest / out_sz;
				end
				if (on_axis && rep != 0)
					digit = digit / 64'(rep);
				src    = (src + digit * stride) & IDX_MASK;
				stride = (stride * in_sz) & IDX_MASK;
			end
			return src[IDX_W-1:0];
		endfunction

		function void note_index(rim_in_t beat);
			rim_out_t want;
			want.src_index = source_index(beat.out_index);
			want.last_out  = beat.is_last;
			pending_src.push_back(want);
			accepted++;
		endfunction

		function void check_map(rim_out_t got);
			rim_out_t want;
			checked++;
			if (pending_src.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS)
					$display("ERROR: map beat %0d (src_index %h last_out %b) with none expected",
						checked, got.src_index, got.last_out);
				reports++;
				return;
			end
			want = pending_src.pop_front();
			if (got.src_index !== want.src_index || got.last_out !== want.last_out) begin
				errors++;
				if (reports < MAX_REPORTS)
					$display("ERROR: map beat %0d src_index exp %h got %h, last_out exp %b got %b",
						checked, want.src_index, got.src_index, want.last_out, got.last_out);
				reports++;
			end
		endfunction
	endclass

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  idx_valid      = 1'b0;
	logic                  idx_stall;
	rim_in_t               idx_data       = '0;
	logic                  map_valid;
	logic                  map_stall      = 1'b0;
	rim_out_t              map_data;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;
	int                    recv_stall_pct = 86;
	int                    beats_sent     = 0;
	int                    shapes_run     = 0;
	int                    quiet_cycles   = 0;
	index_map_sb           sb             = new();

	tensor_repeat_index_map_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.idx_valid (idx_valid),
		.idx_stall (idx_stall),
		.idx_data  (idx_data),
		.map_valid (map_valid),
		.map_stall (map_stall),
		.map_data  (map_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Hold reset from the start, then release it once
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stall the map side at random
	always @(posedge clk) begin
		map_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Observe every handshake; end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if (idx_valid && !idx_stall)
				sb.note_index(idx_data);
			if (map_valid && !map_stall)
				sb.check_map(map_data);
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if ((idx_valid && !idx_stall) || (map_valid && !map_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic shape_t mk_shape(int axis, int rep, int d0, int d1, int d2, int d3,
			int d4, int d5);
		shape_t s;
		s.axis    = AXIS_W'(axis);
		s.rep     = DIM_W'(rep);
		s.dims[0] = DIM_W'(d0);
		s.dims[1] = DIM_W'(d1);
		s.dims[2] = DIM_W'(d2);
		s.dims[3] = DIM_W'(d3);
		s.dims[4] = DIM_W'(d4);
		s.dims[5] = DIM_W'(d5);
		return s;
	endfunction

	// Mostly small sizes, now and then a zero or a huge one
	function automatic shape_t random_shape();
		shape_t s;
		int     r;
		int     k;
		s.axis = AXIS_W'($urandom_range(7));
		case ($urandom_range(3))
			0: s.rep = '0;
			1: s.rep = DIM_W'(1);
			2: s.rep = DIM_W'($urandom_range(2, 9));
			default: s.rep = DIM_W'($urandom);
		endcase
		for (k = 0; k < DIMS; k++) begin
			r = $urandom_range(19);
			s.dims[k] = (r == 0) ? '0 : (r == 1) ? DIM_W'($urandom) : DIM_W'($urandom_range(1, 6));
		end
		return s;
	endfunction

	// Element count of the output tensor, capped at the full index range; a zero count gives the full range
	function automatic logic [32:0] tensor_span(shape_t s);
		logic [63:0] prod;
		logic [63:0] sz;
		int          k;
		prod = 64'd1;
		for (k = 0; k < DIMS; k++) begin
			sz = 64'(s.dims[k]);
			if (k == int'(s.axis))
				sz = sz * 64'(s.rep);
			prod = prod * sz;
			if (prod > 64'(FULL_SPAN))
				prod = 64'(FULL_SPAN);
		end
		return (prod == 0) ? FULL_SPAN : prod[32:0];
	endfunction

	// Offer one index beat, idling first at the rate of the current phase
	task automatic send_index(input logic [IDX_W-1:0] idx, input logic last);
		int gap_pct;
		gap_pct = (beats_sent < 350) ? 19 : (beats_sent < 700) ? 86 : 0;
		recv_stall_pct <= (beats_sent < 350) ? 86 : (beats_sent < 700) ? 19 : 0;
		while ($urandom_range(99) < gap_pct) begin
			idx_valid <= 1'b0;
			@(posedge clk);
		end
		idx_valid          <= 1'b1;
		idx_data.out_index <= idx;
		idx_data.is_last   <= last;
		do @(posedge clk); while (idx_stall);
		beats_sent++;
	endtask

	// Hold off the sender until every owed map beat is back
	task automatic drain();
		idx_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_src.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write all registers, then one spare index that must be ignored
	task automatic program_shape(input shape_t s);
		logic [CFG_DATA_W-1:0] v;
		int                    k;
		v = CFG_DATA_W'($urandom);
		v[AXIS_W-1:0] = s.axis;
		write_reg(REG_AXIS, v);
		write_reg(REG_REPEAT, s.rep);
		for (k = 0; k < DIMS; k++)
			write_reg(CFG_IDX_W'(REG_DIM0 + k), s.dims[k]);
		write_reg(CFG_IDX_W'(REG_DIM5 + 1 + $urandom_range(7)), CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Edge beats, then runs of consecutive indexes mixed with jumps and noise
	task automatic run_shape(input shape_t s);
		logic [32:0] span;
		logic [63:0] cur;
		int          r;
		int          n;
		drain();
		program_shape(s);
		shapes_run++;
		span = tensor_span(s);
		send_index(IDX_W'(span - 1), 1'b1);
		send_index('1, 1'b0);
		cur = 64'(span - 1);
		for (n = 0; n < RAND_PER_SHAPE; n++) begin
			r = $urandom_range(99);
			if (r < 60)
				cur = (cur + 1) % 64'(span);
			else if (r < 85)
				cur = {$urandom, $urandom} % 64'(span);
			else
				cur = 64'($urandom);
			send_index(cur[IDX_W-1:0], (cur == 64'(span - 1)) || ($urandom_range(15) == 0));
		end
	endtask

	initial begin : stimulus
		int k;
		wait (arst_n);
		@(posedge clk);
		// reset defaults: every size is one, so all map to zero
		send_index('0, 1'b0);
		send_index('1, 1'b1);
		run_shape(mk_shape(5, 3, 1, 1, 1, 1, 4, 5));
		run_shape(mk_shape(3, 2, 1, 1, 3, 4, 5, 6));
		run_shape(mk_shape(0, 7, 2, 3, 2, 3, 2, 3));
		// no slot is the repeat axis
		run_shape(mk_shape(6, 5, 1, 2, 3, 4, 5, 6));
		run_shape(mk_shape(7, 65535, 3, 1, 4, 1, 5, 9));
		// zero-sized slot
		run_shape(mk_shape(2, 4, 3, 0, 5, 2, 1, 7));
		// zero repeat count
		run_shape(mk_shape(4, 0, 1, 1, 2, 3, 4, 5));
		// largest sizes; strides wrap
		run_shape(mk_shape(1, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
		run_shape(mk_shape(5, 65535, 1, 1, 1, 1, 1, 65535));
		run_shape(mk_shape(0, 1, 1, 1, 1, 1, 1, 16));
		for (k = 0; k < 3; k++)
			run_shape(random_shape());
		drain();
		repeat (PIPE_LATENCY) @(posedge clk);
		if (sb.pending_src.size() != 0) begin
			$display("ERROR: %0d map beats never arrived", sb.pending_src.size());
			sb.errors += sb.pending_src.size();
		end
		$display("Run covered %0d register settings plus reset defaults under three idle patterns.",
			shapes_run);
		$display("Index beats in: %0d, map beats checked: %0d, mismatches: %0d.",
			sb.accepted, sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
